FILE: rtl/core/wccvs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wccvs_pkg - shared types and constants
// Opcodes, register indexes and reset values of the victim selector.
// ---------------------------------------------------------------------------
package wccvs_pkg;

    localparam int unsigned SETS_DEF       = 64;
    localparam int unsigned WAYS_DEF       = 8;
    localparam int unsigned FREQ_BITS_DEF  = 4;
    localparam int unsigned WC_BITS_DEF    = 4;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned SETI_W  = 6;
    localparam int unsigned WAYI_W  = 3;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned BYTES_W = 11;
    localparam int unsigned COST_W  = 20;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CIDX_W  = 3;

    localparam logic [COST_W-1:0] COST_MAX = '1;
    localparam logic [7:0] K_TENTH = 8'd26;
    localparam logic [7:0] K_FIFTH = 8'd51;

    typedef enum logic [OP_W-1:0] {
        OP_INVALIDATE = 3'd0,
        OP_TOUCH      = 3'd1,
        OP_INSERT     = 3'd2,
        OP_WRITE      = 3'd3,
        OP_UTIL       = 3'd4,
        OP_DIRTY      = 3'd5,
        OP_VICTIM     = 3'd6,
        OP_NONE       = 3'd7
    } t_op;

    typedef enum logic [CIDX_W-1:0] {
        REG_RECENCY = 3'd0,
        REG_FREQ    = 3'd1,
        REG_WRITE   = 3'd2,
        REG_DIRTY   = 3'd3,
        REG_UTIL    = 3'd4,
        REG_WENERGY = 3'd5,
        REG_RENERGY = 3'd6,
        REG_LINE    = 3'd7
    } t_reg;

    localparam logic [CFG_W-1:0]   WEIGHT_RST = 16'd256;
    localparam logic [BYTES_W-1:0] LINE_RST   = 11'd64;

endpackage

FILE: rtl/core/wccvs_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wccvs_ram - generic single port RAM
// One access per cycle: an optional write and a read, registered read data.
// ---------------------------------------------------------------------------
module wccvs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/wccvs_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wccvs_div - radix-2 restoring divider
// Quotient of a 16-bit fraction: (num << 16) / den, num <= den, one bit a
// cycle, the integer bit first and then 16 fraction bits.
// ---------------------------------------------------------------------------
module wccvs_div #(
    parameter int unsigned DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [16:0]   o_quot
);
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [16:0]   r_quot;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW+1:0] n_try;

    assign n_try = {r_rem, 1'b0} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                // first step takes the integer bit, then 16 fraction bits
                if (r_cnt == 5'd0) begin
                    if ({1'b0, r_rem} >= {2'b00, r_den}) begin
                        r_rem  <= r_rem - {1'b0, r_den};
                        r_quot <= 17'd1;
                    end
                end else if (!n_try[DW+1]) begin
                    r_rem  <= n_try[DW:0];
                    r_quot <= {r_quot[15:0], 1'b1};
                end else begin
                    r_rem  <= {r_rem[DW-1:0], 1'b0};
                    r_quot <= {r_quot[15:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: rtl/core/weighted_cost_cache_victim_select.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weighted_cost_cache_victim_select - weighted-cost victim selector
// Per-way replacement metadata and a sequenced cost search over one set.
// ---------------------------------------------------------------------------
// After reset the block clears its metadata store, one entry a cycle, and
// is not ready until every entry is cleared. Update events (invalidate,
// touch, insert, write, utilisation, dirty) step through a metadata read,
// registered read data and a write back before the block is ready again. A
// find-victim word walks the ways of the set one at a time through one
// shared divider and one 16x24 multiplier. Each way costs a metadata read,
// two fraction divisions with their start (age, unused share), a step each
// for the frequency and write intensity fractions (their divisors are
// all-ones constants, so the quotient is the numerator repeated as a binary
// fraction), seven multiply-accumulate steps and a compare. The result sits
// in an output register; the block goes back to idle once it is loaded and
// only holds in its last step while an earlier result still waits there.
// ---------------------------------------------------------------------------
module weighted_cost_cache_victim_select #(
    parameter int unsigned SETS       = wccvs_pkg::SETS_DEF,
    parameter int unsigned WAYS       = wccvs_pkg::WAYS_DEF,
    parameter int unsigned FREQ_BITS  = wccvs_pkg::FREQ_BITS_DEF,
    parameter int unsigned WC_BITS    = wccvs_pkg::WC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wccvs_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [wccvs_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [wccvs_pkg::OP_W-1:0]    i_opcode,
    input  logic [wccvs_pkg::SETI_W-1:0]  i_set_index,
    input  logic [wccvs_pkg::WAYI_W-1:0]  i_way_index,
    input  logic [wccvs_pkg::TIME_W-1:0]  i_current_time,
    input  logic [wccvs_pkg::BYTES_W-1:0] i_bytes_accessed,
    input  logic                          i_dirty_flag,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [wccvs_pkg::WAYI_W-1:0]  o_victim_way,
    output logic [wccvs_pkg::COST_W-1:0]  o_victim_cost
);
    import wccvs_pkg::*;

    localparam int unsigned ENTRIES = SETS * WAYS;
    localparam int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned MW      = TIME_W + FREQ_BITS + WC_BITS + BYTES_W + 1;
    localparam logic [FREQ_BITS-1:0]  FMAX = '1;
    localparam logic [WC_BITS-1:0]    WMAX = '1;

    // metadata word layout: {last, acc, wc, used, dirty}
    localparam int unsigned D_LO = 0;
    localparam int unsigned U_LO = 1;
    localparam int unsigned W_LO = U_LO + BYTES_W;
    localparam int unsigned A_LO = W_LO + WC_BITS;
    localparam int unsigned T_LO = A_LO + FREQ_BITS;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_RDW, S_UPD, S_VRD, S_VRDW, S_DIV, S_DIVW,
        S_MAC, S_CMP, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [CFG_W-1:0]   r_wt [7];
    logic [BYTES_W-1:0] r_line;

    // accepted word
    t_op                r_op;
    logic [SETI_W-1:0]  r_set;
    logic [WW-1:0]      r_way;
    logic [TIME_W-1:0]  r_now;
    logic [BYTES_W-1:0] r_bytes;
    logic               r_dflag;

    // memory and clearing pass
    logic [AW-1:0]      r_clr;
    logic               n_we;
    logic [AW-1:0]      n_addr;
    logic [MW-1:0]      n_wdata;
    logic [MW-1:0]      w_rdata;
    logic [MW-1:0]      w_meta;
    logic [AW-1:0]      w_entry;

    // search state
    logic [1:0]         r_dsel;
    logic [3:0]         r_msel;
    logic [16:0]        r_fac [4];
    logic [MW-1:0]      r_cur;
    logic [63:0]        r_pos;
    logic [63:0]        r_neg;
    logic [COST_W-1:0]  r_best;
    logic [WW-1:0]      r_bway;
    logic [WAYI_W-1:0]  r_oway;
    logic [COST_W-1:0]  r_ocost;
    logic               r_ovalid;

    // divider
    logic               n_dstart;
    logic [TIME_W-1:0]  n_dnum;
    logic [TIME_W-1:0]  n_dden;
    logic               w_ddone;
    logic [16:0]        w_dquot;

    // shared multiplier
    logic [15:0]        n_ma;
    logic [23:0]        n_mb;
    logic [39:0]        w_prod;

    wccvs_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_addr  (n_addr),
        .i_wdata (n_wdata),
        .o_rdata (w_rdata)
    );

    wccvs_div #(.DW(TIME_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_dstart),
        .i_num   (n_dnum),
        .i_den   (n_dden),
        .o_done  (w_ddone),
        .o_quot  (w_dquot)
    );

    assign w_entry = AW'(r_set * WAYS) + AW'(r_way);
    assign w_meta  = w_rdata;

    logic [TIME_W-1:0]     c_last;
    logic [FREQ_BITS-1:0]  c_acc;
    logic [WC_BITS-1:0]    c_wc;
    logic [BYTES_W-1:0]    c_used;
    logic                  c_dirty;
    logic [BYTES_W-1:0]    c_uclip;
    logic [FREQ_BITS-1:0]  c_fnum;
    logic [16:0]           c_ffac;
    logic [16:0]           c_wfac;
    assign c_last  = r_cur[T_LO +: TIME_W];
    assign c_acc   = r_cur[A_LO +: FREQ_BITS];
    assign c_wc    = r_cur[W_LO +: WC_BITS];
    assign c_used  = r_cur[U_LO +: BYTES_W];
    assign c_dirty = r_cur[D_LO];
    assign c_uclip = (c_used > r_line) ? r_line : c_used;
    assign c_fnum  = FMAX - c_acc;

    // x / (2^k - 1) is x repeated as a binary fraction; all ones gives 1.0
    always_comb begin
        c_ffac = '0;
        if (c_fnum == FMAX) begin
            c_ffac = 17'h10000;
        end else begin
            for (int i = 0; i < 16; i++)
                c_ffac[15 - i] = c_fnum[FREQ_BITS - 1 - (i % FREQ_BITS)];
        end
    end

    always_comb begin
        c_wfac = '0;
        if (c_wc == WMAX) begin
            c_wfac = 17'h10000;
        end else begin
            for (int i = 0; i < 16; i++)
                c_wfac[15 - i] = c_wc[WC_BITS - 1 - (i % WC_BITS)];
        end
    end

    // divider operands by step: age, unused share
    always_comb begin
        n_dnum = '0;
        n_dden = 32'd1;
        case (r_dsel)
            2'd0: begin
                if (r_now > c_last) begin
                    n_dnum = r_now - c_last;
                    n_dden = r_now;
                end
            end
            default: begin
                if (r_line != '0) begin
                    n_dnum = TIME_W'(r_line - c_uclip);
                    n_dden = TIME_W'(r_line);
                end
            end
        endcase
    end
    assign n_dstart = (r_state == S_DIV) && (r_dsel == 2'd0 || r_dsel == 2'd3);

    // multiplier operands by step
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (r_msel)
            4'd0: begin n_ma = r_wt[REG_RECENCY]; n_mb = 24'(r_fac[0]); end
            4'd1: begin n_ma = r_wt[REG_FREQ];    n_mb = 24'(r_fac[1]); end
            4'd2: begin n_ma = r_wt[REG_WRITE];   n_mb = 24'(r_fac[2]); end
            4'd3: begin n_ma = r_wt[REG_UTIL];    n_mb = 24'(r_fac[3]); end
            4'd4: begin n_ma = r_wt[REG_RENERGY]; n_mb = 24'(c_acc);    end
            4'd5: begin n_ma = r_wt[REG_WENERGY]; n_mb = 24'(c_wc);     end
            4'd6: begin n_ma = 16'(K_FIFTH);      n_mb = 24'(r_wt[REG_WENERGY]); end
            default: ;
        endcase
    end
    assign w_prod = 40'(n_ma) * 40'(n_mb);

    // metadata update for events
    logic [TIME_W-1:0]     u_last;
    logic [FREQ_BITS-1:0]  u_acc;
    logic [WC_BITS-1:0]    u_wc;
    logic [BYTES_W-1:0]    u_used;
    logic                  u_dirty;
    logic [BYTES_W-1:0]    u_tmp;
    always_comb begin
        u_last  = w_meta[T_LO +: TIME_W];
        u_acc   = w_meta[A_LO +: FREQ_BITS];
        u_wc    = w_meta[W_LO +: WC_BITS];
        u_used  = w_meta[U_LO +: BYTES_W];
        u_dirty = w_meta[D_LO];
        u_tmp   = (r_bytes > u_used) ? r_bytes : u_used;
        case (r_op)
            OP_INVALIDATE: begin
                u_last = '0; u_acc = '0; u_wc = '0; u_used = '0; u_dirty = 1'b0;
            end
            OP_TOUCH: begin
                u_last = r_now;
                if (u_acc != FMAX) u_acc = u_acc + 1'b1;
            end
            OP_INSERT: begin
                u_last = r_now;
                if (u_acc != FMAX) u_acc = u_acc + 1'b1;
                u_wc = '0; u_used = r_line; u_dirty = 1'b0;
            end
            OP_WRITE: begin
                if (u_wc != WMAX) u_wc = u_wc + 1'b1;
            end
            OP_UTIL: u_used = (u_tmp > r_line) ? r_line : u_tmp;
            default: u_dirty = r_dflag;
        endcase
    end

    // clearing pass writes zero words, events write back the updated word
    always_comb begin
        n_we    = (r_state == S_UPD) || (r_state == S_CLR);
        n_wdata = (r_state == S_CLR) ? '0 : {u_last, u_acc, u_wc, u_used, u_dirty};
        n_addr  = (r_state == S_CLR) ? r_clr : w_entry;
    end

    logic w_acc_in;
    assign o_ready  = (r_state == S_IDLE);
    assign w_acc_in = i_valid && o_ready;

    logic [63:0] c_diff;
    logic [COST_W-1:0] c_cost;
    assign c_diff = r_pos - r_neg;
    assign c_cost = (r_pos <= r_neg) ? '0 :
                    (|c_diff[63:36]) ? COST_MAX : c_diff[35:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ovalid <= 1'b0;
            r_clr    <= '0;
            for (int k = 0; k < 7; k++) r_wt[k] <= WEIGHT_RST;
            r_line   <= LINE_RST;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_LINE) r_line <= i_cfg_data[BYTES_W-1:0];
                else r_wt[i_cfg_index] <= i_cfg_data;
            end
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(ENTRIES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_op    <= t_op'(i_opcode);
                        r_set   <= i_set_index;
                        r_way   <= (i_opcode == OP_VICTIM) ? '0 : WW'(i_way_index);
                        r_now   <= i_current_time;
                        r_bytes <= i_bytes_accessed;
                        r_dflag <= i_dirty_flag;
                        if (32'(i_set_index) >= SETS) r_state <= S_IDLE;
                        else if (i_opcode == OP_VICTIM) r_state <= S_VRD;
                        else if (i_opcode == OP_NONE || 32'(i_way_index) >= WAYS)
                            r_state <= S_IDLE;
                        else r_state <= S_RD;
                    end
                end
                S_RD:  r_state <= S_RDW;
                S_RDW: r_state <= S_UPD;
                S_UPD: r_state <= S_IDLE;
                S_VRD: r_state <= S_VRDW;
                S_VRDW: begin
                    r_cur   <= w_meta;
                    r_dsel  <= 2'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // frequency and write intensity need no divider
                    if (r_dsel == 2'd1) begin
                        r_fac[1] <= c_ffac;
                        r_dsel   <= 2'd2;
                    end else if (r_dsel == 2'd2) begin
                        r_fac[2] <= c_wfac;
                        r_dsel   <= 2'd3;
                    end else begin
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (w_ddone) begin
                        r_fac[r_dsel] <= w_dquot;
                        r_dsel        <= r_dsel + 2'd1;
                        if (r_dsel == 2'd3) begin
                            r_msel  <= '0;
                            r_pos   <= '0;
                            r_neg   <= '0;
                            r_state <= S_MAC;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_MAC: begin
                    r_msel <= r_msel + 4'd1;
                    case (r_msel)
                        4'd0, 4'd1, 4'd2, 4'd3: r_pos <= r_pos + 64'(w_prod);
                        // energy terms scaled by 26 and then by 256
                        4'd4, 4'd5: r_pos <= r_pos + (64'(w_prod) * 64'(K_TENTH) << 8);
                        4'd6: begin
                            if (c_dirty) begin
                                r_neg <= 64'(w_prod) << 8;
                                r_pos <= r_pos + (64'(r_wt[REG_DIRTY]) << 16);
                            end
                        end
                        default: r_state <= S_CMP;
                    endcase
                end
                S_CMP: begin
                    if (r_way == '0 || c_cost > r_best) begin
                        r_best <= c_cost;
                        r_bway <= r_way;
                    end
                    if (32'(r_way) == WAYS - 1) begin
                        r_state <= S_OUT;
                    end else begin
                        r_way   <= r_way + 1'b1;
                        r_state <= S_VRD;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_oway   <= WAYI_W'(r_bway);
                        r_ocost  <= r_best;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_victim_way  = r_oway;
    assign o_victim_cost = r_ocost;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready |-> (r_state == S_IDLE))) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready |=> o_valid && $stable(o_victim_cost)))
        else $error("result dropped");
    a_no_write_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIVW) |-> !n_we)) else $error("write during search");
`endif
endmodule
